FILE: rtl/core/asp_pkg.sv
// Shared types and constants for the AIFF stream parser.
// No dependencies; imported by every module of the block.
package asp_pkg;

	localparam logic [31:0] TAG_FORM = 32'h464F524D;
	localparam logic [31:0] TAG_AIFF = 32'h41494646;
	localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
	localparam logic [31:0] TAG_SSND = 32'h53534E44;

	localparam logic [15:0] BITS8  = 16'h0008;
	localparam logic [15:0] BITS16 = 16'h0010;
	localparam logic [15:0] RC11   = 16'h400C;
	localparam logic [15:0] RC22   = 16'h400D;
	localparam logic [15:0] RC44   = 16'h400E;
	localparam logic [7:0]  OFFSET8 = 8'd128;

	localparam logic [15:0] HZ11 = 16'd11025;
	localparam logic [15:0] HZ22 = 16'd22050;
	localparam logic [15:0] HZ44 = 16'd44100;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_TAG = 2'd1;
	localparam logic [1:0] ST_BAD_FMT = 2'd2;
	localparam logic [1:0] ST_TRUNC   = 2'd3;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [8:0] {
		PH_FORM = 9'b000000001,
		PH_FLEN = 9'b000000010,
		PH_AIFF = 9'b000000100,
		PH_CTAG = 9'b000001000,
		PH_CLEN = 9'b000010000,
		PH_COMM = 9'b000100000,
		PH_SKIP = 9'b001000000,
		PH_S8   = 9'b010000000,
		PH_S16  = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] sample;
		logic [1:0]  status;
		logic        last;
	} asp_res_t;

	typedef struct packed {
		logic [1:0] count;
		asp_res_t   res0;
		asp_res_t   res1;
	} asp_push_t;

	typedef struct packed {
		logic        stereo;
		logic        wide;
		logic [15:0] rate_code;
		logic [31:0] frames;
	} asp_fmt_t;

endpackage

FILE: rtl/core/aiff_stream_parser.sv
// Top level of the AIFF stream parser: input register, length register,
// chunk walker and result queue. Depends on asp_pkg, asp_parse, asp_result_fifo.
//
// The slave stream carries the file one byte per transaction. The master
// stream carries results: tuser is 0 for a sample and 1 for the summary that
// closes the run, tlast marks the last result caused by one input byte.
// The user must write the file length via cfg_we/cfg_wdata while the block is idle; not enforced.
//
// Throughput is one byte per cycle while the result queue has space. A byte
// taken is first held in the input register, then walked through the chunk
// state and pushed into a four-entry result queue, whose head is offered on
// the master stream.
// A byte yields at most two results (a sample and the summary), and the
// queue drains one result per cycle while m_axis_tready is high.
// When the receiver stalls, the queue fills; s_axis_tready falls once fewer
// than two entries are free and the input register holds its byte.
// Reset clears the queue, the length register and all parse state, and the
// block then expects the FORM tag. After the summary, bytes are taken and
// dropped until the next reset.
module aiff_stream_parser #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // sample, status, rate_hz, stereo, wide,
	                                    // frame_count, zero fill
	output logic        m_axis_tuser,   // kind
	output logic        m_axis_tlast,   // last
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata       // total_length
);
	import asp_pkg::*;

	logic [LENGTH_BITS-1:0] total_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance, space;
	asp_push_t              push;
	asp_fmt_t               fmt;
	asp_res_t               head;
	logic                   is_sum;
	logic [15:0]            rate_hz;
	logic [31:0]            frame_count;

	assign advance       = valid_s1 && space;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_wdata[LENGTH_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	asp_parse #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.byte_s1      (byte_s1),
		.total_length (total_q),
		.push         (push),
		.fmt          (fmt)
	);

	asp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.head      (head)
	);

	// Format fields are frozen once the summary has been produced, and are zero in sample results.
	always_comb begin
		is_sum = (head.kind == KIND_SUMMARY);
		case (fmt.rate_code)
			RC11:    rate_hz = HZ11;
			RC22:    rate_hz = HZ22;
			RC44:    rate_hz = HZ44;
			default: rate_hz = 16'd0;
		endcase
		frame_count = fmt.wide ? {1'b0, fmt.frames[31:1]} : fmt.frames;
		if (!is_sum) begin
			rate_hz     = 16'd0;
			frame_count = 32'd0;
		end
		m_axis_tdata = {4'h0, frame_count, is_sum && fmt.wide, is_sum && fmt.stereo,
			rate_hz, head.status, head.sample};
		m_axis_tuser = head.kind;
		m_axis_tlast = head.last;
	end

	a_two_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.res1.kind == KIND_SUMMARY && !push.res0.last)
		else $error("two results pushed without a closing summary");

	a_summary_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser |=> !m_axis_tvalid)
		else $error("result offered after the summary");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("summary without tlast");

endmodule

FILE: rtl/core/asp_parse.sv
// Chunk walker of the AIFF stream parser: one registered byte per cycle, while advance is high,
// updates the parse state and yields up to two results. Depends on asp_pkg.
module asp_parse #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             byte_s1,
	input  logic [LENGTH_BITS-1:0] total_length,
	output asp_pkg::asp_push_t     push,
	output asp_pkg::asp_fmt_t      fmt
);
	import asp_pkg::*;

	localparam int W = LENGTH_BITS;

	phase_t         phase_q, phase_d;
	logic [W-1:0]   pos_q, pos_d, pos_inc, flimit_q, flimit_d;
	logic [31:0]    tag_q, tag_d, clen_q, clen_d, prog_q, prog_d, prog_inc;
	logic [31:0]    gather_q, v, frames_q, frames_d, skip_len;
	logic [1:0]     chan_q, chan_d;
	logic [15:0]    bits_q, bits_d, rate_q, rate_d;
	logic [7:0]     hi_q, hi_d;
	logic           seen_q, seen_d, finished_q;
	logic           trunc, bnd, fin, smp;
	logic [1:0]     fin_st;
	logic [15:0]    smp_val;
	logic [32:0]    form_sum, skip_end, total_ext, v_ext;
	asp_res_t       summary, sample_res;

	assign v         = {gather_q[23:0], byte_s1};
	assign pos_inc   = pos_q + 1'b1;
	assign prog_inc  = prog_q + 32'd1;
	assign trunc     = pos_q >= total_length;
	assign total_ext = {{(33 - W){1'b0}}, total_length};
	assign v_ext     = {1'b0, v};
	assign form_sum  = v_ext + 33'd8;
	assign skip_end  = {{(33 - W){1'b0}}, pos_inc} + v_ext;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_inc;
		flimit_d = flimit_q;
		tag_d    = tag_q;
		clen_d   = clen_q;
		prog_d   = prog_inc;
		frames_d = frames_q;
		chan_d   = chan_q;
		bits_d   = bits_q;
		rate_d   = rate_q;
		hi_d     = hi_q;
		seen_d   = seen_q;
		bnd      = 1'b0;
		fin      = 1'b0;
		fin_st   = ST_OK;
		smp      = 1'b0;
		smp_val  = '0;
		skip_len = '0;
		if (phase_q == PH_FORM || phase_q == PH_AIFF) begin
			if (prog_inc >= 32'd4) begin
				if (v != ((phase_q == PH_FORM) ? TAG_FORM : TAG_AIFF)) begin
					fin    = 1'b1;
					fin_st = ST_BAD_TAG;
				end else if (trunc) begin
					fin    = 1'b1;
					fin_st = ST_TRUNC;
				end else begin
					prog_d = '0;
					if (phase_q == PH_FORM) begin
						phase_d = PH_FLEN;
					end else begin
						bnd = 1'b1;
					end
				end
			end
		end else if (trunc) begin
			fin    = 1'b1;
			fin_st = ST_TRUNC;
		end else begin
			case (phase_q)
				PH_FLEN: begin
					if (prog_inc >= 32'd4) begin
						if (form_sum > total_ext) begin
							fin    = 1'b1;
							fin_st = ST_TRUNC;
						end else begin
							flimit_d = form_sum[W-1:0];
							phase_d  = PH_AIFF;
							prog_d   = '0;
						end
					end
				end
				PH_CTAG: begin
					if (prog_inc >= 32'd4) begin
						tag_d   = v;
						phase_d = PH_CLEN;
						prog_d  = '0;
					end
				end
				PH_CLEN: begin
					if (prog_inc >= 32'd4) begin
						clen_d = v;
						prog_d = '0;
						if (tag_q == TAG_COMM) begin
							phase_d = PH_COMM;
						end else if (tag_q == TAG_SSND && (bits_q inside {BITS8, BITS16})) begin
							if (v_ext > total_ext) begin
								fin    = 1'b1;
								fin_st = ST_TRUNC;
							end else begin
								seen_d = 1'b1;
								if (bits_q == BITS8) begin
									phase_d = PH_S8;
									bnd     = (v == 32'd0);
								end else begin
									phase_d = PH_S16;
									clen_d  = {v[31:1], 1'b0};
									bnd     = (v[31:1] == 31'd0);
								end
							end
						end else if (skip_end > total_ext) begin
							fin    = 1'b1;
							fin_st = ST_TRUNC;
						end else begin
							phase_d = PH_SKIP;
							clen_d  = v;
							bnd     = (v == 32'd0);
						end
					end
				end
				PH_COMM: begin
					case (prog_inc)
						32'd2: begin
							if (!(v[15:0] inside {16'd1, 16'd2})) begin
								fin    = 1'b1;
								fin_st = ST_BAD_FMT;
							end else begin
								chan_d = v[1:0];
							end
						end
						32'd6: begin
							if (v_ext > total_ext) begin
								fin    = 1'b1;
								fin_st = ST_BAD_FMT;
							end else begin
								frames_d = v;
							end
						end
						32'd8: begin
							if (!(v[15:0] inside {BITS8, BITS16})) begin
								fin    = 1'b1;
								fin_st = ST_BAD_FMT;
							end else begin
								bits_d = v[15:0];
							end
						end
						32'd10: begin
							if (!(v[15:0] inside {RC11, RC22, RC44})) begin
								fin    = 1'b1;
								fin_st = ST_BAD_FMT;
							end else begin
								rate_d = v[15:0];
							end
						end
						32'd12: begin
							skip_len = (clen_q >= 32'd12) ? clen_q - 32'd12 : 32'd0;
							phase_d  = PH_SKIP;
							clen_d   = skip_len;
							prog_d   = '0;
							bnd      = (skip_len == 32'd0);
						end
						default: begin
						end
					endcase
				end
				PH_SKIP: begin
					bnd = prog_inc >= clen_q;
				end
				PH_S8: begin
					smp     = 1'b1;
					smp_val = {8'h00, byte_s1 - OFFSET8};
					bnd     = prog_inc >= clen_q;
				end
				PH_S16: begin
					if (prog_inc[0]) begin
						hi_d = byte_s1;
					end else begin
						smp     = 1'b1;
						smp_val = {hi_q, byte_s1};
						bnd     = prog_inc >= clen_q;
					end
				end
				default: begin
					fin    = 1'b1;
					fin_st = ST_TRUNC;
				end
			endcase
		end
		if (bnd) begin
			if (pos_inc >= flimit_q) begin
				fin    = 1'b1;
				fin_st = seen_d ? ST_OK : ST_TRUNC;
			end else begin
				phase_d = PH_CTAG;
				prog_d  = '0;
			end
		end
	end

	always_comb begin
		summary    = '{kind: KIND_SUMMARY, sample: 16'h0000, status: fin_st, last: 1'b1};
		sample_res = '{kind: KIND_SAMPLE, sample: smp_val, status: ST_OK, last: !fin};
		push.count = 2'd0;
		push.res0  = summary;
		push.res1  = summary;
		if (advance && !finished_q) begin
			if (smp) begin
				push.res0  = sample_res;
				push.count = fin ? 2'd2 : 2'd1;
			end else if (fin) begin
				push.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FORM;
			pos_q      <= '0;
			flimit_q   <= '0;
			tag_q      <= '0;
			clen_q     <= '0;
			prog_q     <= '0;
			gather_q   <= '0;
			chan_q     <= '0;
			bits_q     <= '0;
			rate_q     <= '0;
			frames_q   <= '0;
			hi_q       <= '0;
			seen_q     <= 1'b0;
			finished_q <= 1'b0;
		end else if (advance && !finished_q) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			flimit_q   <= flimit_d;
			tag_q      <= tag_d;
			clen_q     <= clen_d;
			prog_q     <= prog_d;
			gather_q   <= v;
			chan_q     <= chan_d;
			bits_q     <= bits_d;
			rate_q     <= rate_d;
			frames_q   <= frames_d;
			hi_q       <= hi_d;
			seen_q     <= seen_d;
			finished_q <= fin;
		end
	end

	assign fmt.stereo    = (chan_q == 2'd2);
	assign fmt.wide      = (bits_q == BITS16);
	assign fmt.rate_code = rate_q;
	assign fmt.frames    = frames_q;

endmodule

FILE: rtl/core/asp_result_fifo.sv
// Small result queue that takes up to two results per cycle and gives one while out_ready is high.
// Depends on asp_pkg.
module asp_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  asp_pkg::asp_push_t push,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output asp_pkg::asp_res_t head
);
	import asp_pkg::*;

	asp_res_t             mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign space     = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + 1'b1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + FIFO_CW'(push.count) - FIFO_CW'(pop);
		end
	end

endmodule
